### design/bcdc_pkg.sv
package bcdc_pkg;

	localparam logic [7:0] SEC_WRAP   = 8'h60;
	localparam logic [7:0] HOUR_WRAP  = 8'h24;
	localparam logic [7:0] MONTH_LAST = 8'h12;
	localparam logic [7:0] YEAR_WRAP  = 8'hA0;
	localparam logic [7:0] LEAP_FEB   = 8'h29;
	localparam logic [7:0] LONG_MONTH = 8'h31;
	localparam logic [7:0] FIRST_DAY  = 8'h01;
	localparam logic [3:0] LOOP_TICKS = 4'd10;
	localparam logic [7:0] LCD_RESET  = 8'd3;

	localparam logic [7:0] MONTH_LEN [12] = '{
		8'h31, 8'h28, 8'h31, 8'h30, 8'h31, 8'h30,
		8'h31, 8'h31, 8'h30, 8'h31, 8'h30, 8'h31
	};

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_LOAD = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [0:0] req_type;
		logic [6:0] load_second;
		logic [6:0] load_minute;
		logic [5:0] load_hour;
		logic [5:0] load_day;
		logic [4:0] load_month;
		logic [7:0] load_year;
	} req_word_t;

	typedef struct packed {
		logic [6:0] second_bcd;
		logic [6:0] minute_bcd;
		logic [5:0] hour_bcd;
		logic [5:0] day_bcd;
		logic [4:0] month_bcd;
		logic [7:0] year_bcd;
		logic [0:0] second_pulse;
		logic [0:0] minute_pulse;
		logic [0:0] month_pulse;
		logic [0:0] blink_level;
		logic [0:0] loop_pulse;
		logic [0:0] display_pulse;
	} res_word_t;

	typedef struct packed {
		logic [6:0] second;
		logic [6:0] minute;
		logic [5:0] hour;
		logic [5:0] day;
		logic [4:0] month;
		logic [7:0] year;
	} cal_t;

	typedef struct packed {
		logic       half_phase;
		logic       blink;
		logic [3:0] loop_count;
		logic [8:0] display_count;
	} tick_state_t;

	typedef struct packed {
		logic second;
		logic loop;
		logic display;
	} tick_pulse_t;

	// A low digit of 9 or more carries into the high digit; the result wraps in 8 bits.
	function automatic logic [7:0] bcd_inc(input logic [7:0] v);
		logic [7:0] r;
		if (v[3:0] >= 4'd9) begin
			r = {v[7:4] + 4'd1, 4'd0};
		end else begin
			r = v + 8'd1;
		end
		return r;
	endfunction

	// Days in the current month. Month digits are read as tens and units, so
	// codes such as 0x0A count as month ten; anything outside one to twelve
	// has 31 days. The leap test uses (10*tens + units) mod 4 = (2*tens + units) mod 4.
	function automatic logic [7:0] month_limit(input logic [4:0] month,
			input logic [7:0] year);
		logic [4:0] m;
		logic [3:0] idx;
		logic [1:0] leap_mod;
		logic [7:0] r;
		m        = month[4] ? (5'd10 + {1'b0, month[3:0]}) : {1'b0, month[3:0]};
		idx      = 4'(m - 5'd1);
		leap_mod = 2'({year[6:4], 1'b0} + year[3:0]);
		if (m < 5'd1 || m > 5'd12) begin
			r = LONG_MONTH;
		end else if (m == 5'd2 && leap_mod == 2'd0) begin
			r = LEAP_FEB;
		end else begin
			r = MONTH_LEN[idx];
		end
		return r;
	endfunction

endpackage

### design/bcdc_calendar.sv
module bcdc_calendar (
	input  bcdc_pkg::cal_t cur,
	output bcdc_pkg::cal_t nxt,
	output logic           minute_wrap,
	output logic           month_wrap
);
	import bcdc_pkg::*;

	logic [7:0] sec_inc;
	logic [7:0] min_inc;
	logic [7:0] hour_inc;
	logic [7:0] day_inc;
	logic [7:0] mon_inc;
	logic [7:0] year_inc;

	assign sec_inc  = bcd_inc({1'b0, cur.second});
	assign min_inc  = bcd_inc({1'b0, cur.minute});
	assign hour_inc = bcd_inc({2'b00, cur.hour});
	assign day_inc  = bcd_inc({2'b00, cur.day});
	assign mon_inc  = bcd_inc({3'b000, cur.month});
	assign year_inc = bcd_inc(cur.year);

	// One second of carry chain; each unit only moves when the one below wrapped.
	always_comb begin
		nxt         = cur;
		minute_wrap = 1'b0;
		month_wrap  = 1'b0;
		nxt.second  = sec_inc[6:0];
		if (sec_inc >= SEC_WRAP) begin
			nxt.second  = '0;
			minute_wrap = 1'b1;
			nxt.minute  = min_inc[6:0];
			if (min_inc >= SEC_WRAP) begin
				nxt.minute = '0;
				nxt.hour   = hour_inc[5:0];
				if (hour_inc >= HOUR_WRAP) begin
					nxt.hour = '0;
					nxt.day  = day_inc[5:0];
					if (day_inc > month_limit(cur.month, cur.year)) begin
						nxt.day    = FIRST_DAY[5:0];
						month_wrap = 1'b1;
						nxt.month  = mon_inc[4:0];
						if (mon_inc > MONTH_LAST) begin
							nxt.month = FIRST_DAY[4:0];
							nxt.year  = (year_inc >= YEAR_WRAP) ? 8'h00 : year_inc;
						end
					end
				end
			end
		end
	end

endmodule

### design/bcdc_ticker.sv
module bcdc_ticker (
	input  bcdc_pkg::tick_state_t cur,
	input  logic [7:0]            lcd_cycle,
	output bcdc_pkg::tick_state_t nxt,
	output bcdc_pkg::tick_pulse_t pulse
);
	import bcdc_pkg::*;

	logic [3:0] loop_inc;
	logic [8:0] disp_inc;

	assign loop_inc = cur.loop_count + 4'd1;
	assign disp_inc = cur.display_count + 9'd1;

	always_comb begin
		nxt.half_phase = ~cur.half_phase;
		nxt.blink      = cur.blink ^ cur.half_phase;
		pulse.second   = cur.half_phase;

		pulse.loop     = (loop_inc >= LOOP_TICKS);
		nxt.loop_count = pulse.loop ? 4'd0 : loop_inc;

		// The period is counted in half-second ticks; a period of zero fires every tick.
		pulse.display     = (disp_inc >= {lcd_cycle, 1'b0});
		nxt.display_count = pulse.display ? 9'd0 : disp_inc;
	end

endmodule

### design/bcd_calendar_clock_top.sv
// Channel  Signals                          Width            Direction
// req      req_valid req_ready req_word     1 / 1 / 40       in / out / in
// res      res_valid res_ready res_word     1 / 1 / 45       out / in / out
// cfg      cfg_we cfg_wdata                 1 / 8            in / in
//
// One word is accepted per cycle unless the result stalls; a request word is registered
// in req_s1 and its result in res_s2. The carry chain is combinational from the input
// register to the result register, which also updates the clock and tick state.
// arst_n clears the clock to 00:00:00 day 01 month 01 year 00, the counters and the
// display period (3 seconds). A stalled result holds the input register and, once
// that is full, drops req_ready.
module bcd_calendar_clock_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bcdc_pkg::req_word_t req_word,
	output logic                res_valid,
	input  logic                res_ready,
	output bcdc_pkg::res_word_t res_word,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);
	import bcdc_pkg::*;

	req_word_t   req_s1;
	logic        valid_s1;
	res_word_t   res_s2;
	logic        valid_s2;
	logic [7:0]  lcd_cycle_q;
	cal_t        cal_q;
	tick_state_t tick_q;

	cal_t        cal_nxt;
	logic        minute_wrap;
	logic        month_wrap;
	tick_state_t tick_nxt;
	tick_pulse_t pulse;
	logic        advance;
	logic        is_load;

	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;
	assign is_load   = (req_kind_t'(req_s1.req_type) == REQ_LOAD);

	bcdc_calendar u_calendar (
		.cur         (cal_q),
		.nxt         (cal_nxt),
		.minute_wrap (minute_wrap),
		.month_wrap  (month_wrap)
	);

	bcdc_ticker u_ticker (
		.cur       (tick_q),
		.lcd_cycle (lcd_cycle_q),
		.nxt       (tick_nxt),
		.pulse     (pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_cycle_q <= LCD_RESET;
		end else if (cfg_we) begin
			lcd_cycle_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cal_q    <= '{second: 7'h00, minute: 7'h00, hour: 6'h00,
			              day: FIRST_DAY[5:0], month: FIRST_DAY[4:0], year: 8'h00};
			tick_q   <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				if (is_load) begin
					cal_q <= '{second: req_s1.load_second, minute: req_s1.load_minute,
					           hour: req_s1.load_hour, day: req_s1.load_day,
					           month: req_s1.load_month, year: req_s1.load_year};
				end else begin
					tick_q <= tick_nxt;
					if (tick_q.half_phase) begin
						cal_q <= cal_nxt;
					end
				end
			end
		end
	end

	// The result word shows the state as it stands after this request.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (is_load) begin
				res_s2.second_bcd    <= req_s1.load_second;
				res_s2.minute_bcd    <= req_s1.load_minute;
				res_s2.hour_bcd      <= req_s1.load_hour;
				res_s2.day_bcd       <= req_s1.load_day;
				res_s2.month_bcd     <= req_s1.load_month;
				res_s2.year_bcd      <= req_s1.load_year;
				res_s2.second_pulse  <= 1'b0;
				res_s2.minute_pulse  <= 1'b0;
				res_s2.month_pulse   <= 1'b0;
				res_s2.blink_level   <= tick_q.blink;
				res_s2.loop_pulse    <= 1'b0;
				res_s2.display_pulse <= 1'b0;
			end else begin
				if (tick_q.half_phase) begin
					res_s2.second_bcd <= cal_nxt.second;
					res_s2.minute_bcd <= cal_nxt.minute;
					res_s2.hour_bcd   <= cal_nxt.hour;
					res_s2.day_bcd    <= cal_nxt.day;
					res_s2.month_bcd  <= cal_nxt.month;
					res_s2.year_bcd   <= cal_nxt.year;
				end else begin
					res_s2.second_bcd <= cal_q.second;
					res_s2.minute_bcd <= cal_q.minute;
					res_s2.hour_bcd   <= cal_q.hour;
					res_s2.day_bcd    <= cal_q.day;
					res_s2.month_bcd  <= cal_q.month;
					res_s2.year_bcd   <= cal_q.year;
				end
				res_s2.second_pulse  <= pulse.second;
				res_s2.minute_pulse  <= pulse.second && minute_wrap;
				res_s2.month_pulse   <= pulse.second && month_wrap;
				res_s2.blink_level   <= tick_nxt.blink;
				res_s2.loop_pulse    <= pulse.loop;
				res_s2.display_pulse <= pulse.display;
			end
		end
	end

	assign res_valid = valid_s2;
	assign res_word  = res_s2;

endmodule

### sim/bcd_calendar_clock_top_test.sv
module bcd_calendar_clock_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bcdc_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_word_t  req_word = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_word_t  res_word;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	bcd_calendar_clock_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Calendar state as the block should hold it.
	logic [7:0] cal_sec = 8'h00;
	logic [7:0] cal_min = 8'h00;
	logic [7:0] cal_hour = 8'h00;
	logic [7:0] cal_day = 8'h01;
	logic [7:0] cal_mon = 8'h01;
	logic [7:0] cal_year = 8'h00;
	logic       half_tick = 1'b0;
	logic       blink = 1'b0;
	logic [3:0] loop_cnt = 4'd0;
	logic [8:0] disp_cnt = 9'd0;
	logic [7:0] disp_period = LCD_RESET;

	req_word_t  pending_words[$];
	res_word_t  expected_results[$];
	res_word_t  oldest_result;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         words_queued = 0;
	int         results_checked = 0;
	int         errors = 0;
	int         n_ticks = 0;
	int         n_loads = 0;
	int         n_month_rolls = 0;
	int         n_display = 0;
	int         n_periods = 1;

	function automatic logic [7:0] next_bcd(input logic [7:0] v);
		if (v[3:0] >= 4'd9) begin
			return {v[7:4] + 4'd1, 4'd0};
		end
		return v + 8'd1;
	endfunction

	function automatic logic [7:0] bcd8(input int n);
		return {4'(n / 10), 4'(n % 10)};
	endfunction

	// Digits are weighted as tens and units even when they are not valid BCD.
	function automatic logic [7:0] days_in_month(input logic [7:0] m, input logic [7:0] y);
		int mv;
		int yv;
		mv = int'(m[7:4]) * 10 + int'(m[3:0]);
		yv = int'(y[7:4]) * 10 + int'(y[3:0]);
		case (mv)
			2: begin
				return (yv % 4 == 0) ? 8'h29 : 8'h28;
			end
			4, 6, 9, 11: begin
				return 8'h30;
			end
			default: begin
				return 8'h31;
			end
		endcase
	endfunction

	function automatic res_word_t calendar_step(input req_word_t w);
		res_word_t r;
		logic      sec_p;
		logic      min_p;
		logic      mon_p;
		logic      loop_p;
		logic      disp_p;
		sec_p = 1'b0;
		min_p = 1'b0;
		mon_p = 1'b0;
		loop_p = 1'b0;
		disp_p = 1'b0;
		if (w.req_type == REQ_LOAD) begin
			n_loads++;
			cal_sec = {1'b0, w.load_second};
			cal_min = {1'b0, w.load_minute};
			cal_hour = {2'b0, w.load_hour};
			cal_day = {2'b0, w.load_day};
			cal_mon = {3'b0, w.load_month};
			cal_year = w.load_year;
		end else begin
			n_ticks++;
			if (half_tick) begin
				half_tick = 1'b0;
				sec_p = 1'b1;
				blink = ~blink;
				cal_sec = next_bcd(cal_sec);
				if (cal_sec >= SEC_WRAP) begin
					cal_sec = 8'h00;
					min_p = 1'b1;
					cal_min = next_bcd(cal_min);
					if (cal_min >= SEC_WRAP) begin
						cal_min = 8'h00;
						cal_hour = next_bcd(cal_hour);
						if (cal_hour >= HOUR_WRAP) begin
							cal_hour = 8'h00;
							cal_day = next_bcd(cal_day);
							if (cal_day > days_in_month(cal_mon, cal_year)) begin
								cal_day = FIRST_DAY;
								mon_p = 1'b1;
								n_month_rolls++;
								cal_mon = next_bcd(cal_mon);
								if (cal_mon > MONTH_LAST) begin
									cal_mon = FIRST_DAY;
									cal_year = next_bcd(cal_year);
									if (cal_year >= YEAR_WRAP) begin
										cal_year = 8'h00;
									end
								end
							end
						end
					end
				end
			end else begin
				half_tick = 1'b1;
			end
			loop_cnt = loop_cnt + 4'd1;
			if (loop_cnt >= LOOP_TICKS) begin
				loop_cnt = 4'd0;
				loop_p = 1'b1;
			end
			disp_cnt = disp_cnt + 9'd1;
			if (disp_cnt >= {disp_period, 1'b0}) begin
				disp_cnt = 9'd0;
				disp_p = 1'b1;
				n_display++;
			end
		end
		r.second_bcd = cal_sec[6:0];
		r.minute_bcd = cal_min[6:0];
		r.hour_bcd = cal_hour[5:0];
		r.day_bcd = cal_day[5:0];
		r.month_bcd = cal_mon[4:0];
		r.year_bcd = cal_year;
		r.second_pulse = sec_p;
		r.minute_pulse = min_p;
		r.month_pulse = mon_p;
		r.blink_level = blink;
		r.loop_pulse = loop_p;
		r.display_pulse = disp_p;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	task automatic compare_result(input res_word_t want, input res_word_t got);
		check_field("second_bcd", 8'(want.second_bcd), 8'(got.second_bcd));
		check_field("minute_bcd", 8'(want.minute_bcd), 8'(got.minute_bcd));
		check_field("hour_bcd", 8'(want.hour_bcd), 8'(got.hour_bcd));
		check_field("day_bcd", 8'(want.day_bcd), 8'(got.day_bcd));
		check_field("month_bcd", 8'(want.month_bcd), 8'(got.month_bcd));
		check_field("year_bcd", want.year_bcd, got.year_bcd);
		check_field("second_pulse", 8'(want.second_pulse), 8'(got.second_pulse));
		check_field("minute_pulse", 8'(want.minute_pulse), 8'(got.minute_pulse));
		check_field("month_pulse", 8'(want.month_pulse), 8'(got.month_pulse));
		check_field("blink_level", 8'(want.blink_level), 8'(got.blink_level));
		check_field("loop_pulse", 8'(want.loop_pulse), 8'(got.loop_pulse));
		check_field("display_pulse", 8'(want.display_pulse), 8'(got.display_pulse));
	endtask

	// The expected result is formed when the request word is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				expected_results.push_back(calendar_step(req_word));
			end
			if (!req_valid || req_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_word <= pending_words.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t ns: result word expected none got %h", $time, res_word);
				end else begin
					oldest_result = expected_results.pop_front();
					compare_result(oldest_result, res_word);
					results_checked++;
				end
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic req_word_t random_bits();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return req_word_t'(raw[$bits(req_word_t)-1:0]);
	endfunction

	// Mostly loads just short of a rollover, so the carry chain is exercised far up.
	function automatic req_word_t random_load();
		req_word_t  w;
		logic [7:0] sb;
		logic [7:0] mb;
		logic [7:0] hb;
		logic [7:0] db;
		logic [7:0] monb;
		logic [7:0] yb;
		w = random_bits();
		w.req_type = REQ_LOAD;
		if ($urandom_range(9) < 7) begin
			sb = ($urandom_range(3) != 0) ? 8'h59 : bcd8($urandom_range(59));
			mb = ($urandom_range(3) != 0) ? 8'h59 : bcd8($urandom_range(59));
			hb = ($urandom_range(3) != 0) ? 8'h23 : bcd8($urandom_range(23));
			monb = bcd8($urandom_range(12, 1));
			yb = ($urandom_range(7) == 0) ? 8'h99 : bcd8($urandom_range(99));
			db = ($urandom_range(1) != 0) ? days_in_month(monb, yb) : bcd8($urandom_range(28, 1));
			w.load_second = sb[6:0];
			w.load_minute = mb[6:0];
			w.load_hour = hb[5:0];
			w.load_day = db[5:0];
			w.load_month = monb[4:0];
			w.load_year = yb;
		end
		return w;
	endfunction

	task automatic push_word(input req_word_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_tick();
		req_word_t w;
		w = random_bits();
		w.req_type = REQ_TICK;
		push_word(w);
	endtask

	// A load followed by two ticks, so one of them completes a second.
	task automatic push_load_ticks(input logic [7:0] s, input logic [7:0] m,
			input logic [7:0] h, input logic [7:0] d, input logic [7:0] mo,
			input logic [7:0] y);
		req_word_t w;
		w.req_type = REQ_LOAD;
		w.load_second = s[6:0];
		w.load_minute = m[6:0];
		w.load_hour = h[5:0];
		w.load_day = d[5:0];
		w.load_month = mo[4:0];
		w.load_year = y;
		push_word(w);
		push_tick();
		push_tick();
	endtask

	task automatic wait_drained();
		while (results_checked != words_queued) begin
			@(posedge clk);
		end
	endtask

	task automatic write_period(input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		disp_period = v;
		n_periods++;
	endtask

	// Each phase also holds the sender halfway through until every result is back.
	task automatic run_phase(input int s_idle, input int r_idle, input logic [7:0] period,
			input int count);
		wait_drained();
		repeat (4) @(posedge clk);
		write_period(period);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				wait_drained();
			end
			if ($urandom_range(99) < 15) begin
				push_word(random_load());
			end else begin
				push_tick();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with the display period left at its reset value.
		send_idle_pct = 33;
		recv_idle_pct = 52;
		push_tick();
		push_tick();
		push_load_ticks(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);
		push_load_ticks(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h24);
		push_load_ticks(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h24);
		push_load_ticks(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h23);
		push_load_ticks(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'hFF);
		push_load_ticks(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h9F);
		push_load_ticks(8'h59, 8'h59, 8'h23, 8'h31, 8'h0A, 8'h9F);

		run_phase(33, 52, 8'd0, 580);
		run_phase(52, 33, 8'd255, 680);
		run_phase(0, 0, 8'd1, 250);
		run_phase(0, 0, 8'($urandom_range(254, 2)), 240);

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t ns: %0d results never arrived", $time, expected_results.size());
		end
		$display("Covered %0d ticks and %0d loads, %0d month rollovers and %0d display pulses",
			n_ticks, n_loads, n_month_rolls, n_display);
		$display("over %0d display period settings; %0d field mismatches.", n_periods, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
